// ===== hw/rtl/tle_pkg.sv =====
// ============================================================================
// Terminal line editor package
// Shared character codes and the command and status bundles that pass
// between the line editor controller and its datapath.
// ============================================================================
package tle_pkg;

    // Character codes recognised or produced by the editor
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Source of the byte loaded into the output register
    typedef enum logic [1:0] {
        SEL_CONST = 2'd0,
        SEL_RX    = 2'd1,
        SEL_LINE  = 2'd2
    } t_out_sel;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;       // load a word into the output register
        t_out_sel   sel;        // where the byte comes from
        logic [7:0] const_byte; // echo character when sel is SEL_CONST
        logic       last;       // final word caused by the current byte
        logic       store;      // write the received byte into the line store
        logic       cnt_inc;
        logic       cnt_dec;
        logic       cnt_clr;
        logic       idx_step;   // advance the line read index
        logic       idx_clr;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic slot_free;  // output register empty or being drained
        logic cnt_zero;
        logic cnt_full;
        logic idx_final;  // read index is on the last stored byte
        logic rx_term;    // received byte is CR or LF
        logic rx_erase;   // received byte is BS or DEL
    } t_dp_status;

endpackage

// ===== hw/rtl/tle_ctrl.sv =====
// ============================================================================
// Terminal line editor controller
// Sequences the echo and line words for each received byte and drives the
// input handshake.
// ============================================================================
module tle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  tle_pkg::t_dp_status i_status,
    output tle_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LF,
        ST_LINE,
        ST_ERASE_SP,
        ST_ERASE_BS
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_rx_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.sel  = tle_pkg::SEL_CONST;
        unique case (r_state)
            ST_IDLE: begin
                o_rx_ready = i_status.slot_free;
                if (i_rx_valid && i_status.slot_free) begin
                    if (i_status.rx_term) begin
                        o_cmd.load       = 1'b1;
                        o_cmd.const_byte = tle_pkg::CH_CR;
                        n_state          = ST_LF;
                    end else if (i_status.rx_erase) begin
                        if (!i_status.cnt_zero) begin
                            o_cmd.load       = 1'b1;
                            o_cmd.const_byte = tle_pkg::CH_BS;
                            o_cmd.cnt_dec    = 1'b1;
                            n_state          = ST_ERASE_SP;
                        end
                    end else if (!i_status.cnt_full) begin
                        o_cmd.load    = 1'b1;
                        o_cmd.sel     = tle_pkg::SEL_RX;
                        o_cmd.last    = 1'b1;
                        o_cmd.store   = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_LF: begin
                if (i_status.slot_free) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.const_byte = tle_pkg::CH_LF;
                    o_cmd.last       = i_status.cnt_zero;
                    n_state          = i_status.cnt_zero ? ST_IDLE : ST_LINE;
                end
            end
            ST_LINE: begin
                if (i_status.slot_free) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.sel      = tle_pkg::SEL_LINE;
                    o_cmd.last     = i_status.idx_final;
                    o_cmd.idx_step = 1'b1;
                    if (i_status.idx_final) begin
                        o_cmd.cnt_clr = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            ST_ERASE_SP: begin
                if (i_status.slot_free) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.const_byte = tle_pkg::CH_SPACE;
                    n_state          = ST_ERASE_BS;
                end
            end
            ST_ERASE_BS: begin
                if (i_status.slot_free) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.const_byte = tle_pkg::CH_BS;
                    o_cmd.last       = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/tle_dp.sv =====
// ============================================================================
// Terminal line editor datapath
// Line store memory, fill count, line read index and the output register.
// ============================================================================
module tle_dp #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_rx_byte,
    input  tle_pkg::t_dp_cmd    i_cmd,
    output tle_pkg::t_dp_status o_status,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_out_kind,
    output logic                o_out_line_end,
    output logic                o_out_last
);

    localparam int DEPTH = LINE_CAPACITY - 1;
    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rd_data;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_kind;
    logic             r_out_line_end;
    logic             r_out_last;
    logic [7:0]       n_out_byte;

    // Status towards the controller
    always_comb begin
        o_status.slot_free = !r_out_valid || i_out_ready;
        o_status.cnt_zero  = (r_cnt == '0);
        o_status.cnt_full  = (r_cnt == CNT_W'(DEPTH));
        o_status.idx_final = (CNT_W'(r_idx + 1'b1) == r_cnt);
        o_status.rx_term   = (i_rx_byte == tle_pkg::CH_CR) || (i_rx_byte == tle_pkg::CH_LF);
        o_status.rx_erase  = (i_rx_byte == tle_pkg::CH_BS) || (i_rx_byte == tle_pkg::CH_DEL);
    end

    // Next read index; the memory is read at it so the data lines up
    always_comb begin
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_step) begin
            n_idx = CNT_W'(r_idx + 1'b1);
        end else begin
            n_idx = r_idx;
        end
    end

    // Line store memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_cnt[IDX_W-1:0]] <= i_rx_byte;
        end
        r_rd_data <= r_mem[n_idx[IDX_W-1:0]];
    end

    // Fill count and read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= CNT_W'(r_cnt - 1'b1);
            end
        end
    end

    // Output byte selection
    always_comb begin
        case (i_cmd.sel)
            tle_pkg::SEL_RX:   n_out_byte = i_rx_byte;
            tle_pkg::SEL_LINE: n_out_byte = r_rd_data;
            default:           n_out_byte = i_cmd.const_byte;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_byte     <= n_out_byte;
            r_out_kind     <= (i_cmd.sel == tle_pkg::SEL_LINE);
            r_out_line_end <= (i_cmd.sel == tle_pkg::SEL_LINE) && i_cmd.last;
            r_out_last     <= i_cmd.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_out_kind     = r_out_kind;
    assign o_out_line_end = r_out_line_end;
    assign o_out_last     = r_out_last;

endmodule

// ===== hw/rtl/terminal_line_editor_echo.sv =====
// ============================================================================
// Terminal line editor with echo
// Console line editing: stores typed bytes, echoes them, handles erase and
// hands over the completed line on CR or LF.
// ============================================================================
//
//   Channel   Direction  tdata         tuser                     tlast
//   s_axis    in         rx_byte[7:0]  -                         -
//   m_axis    out        out_byte[7:0] [0] out_kind [1] line_end last
//
// An ordinary byte is taken and, unless the line is full, its echo word
// loaded with it. CR or LF emits CR, LF and the stored line; erase emits BS,
// space, BS (nothing on an empty line). Output words go through the output
// register at one word per cycle while m_axis keeps up. Input is held off
// while those words are emitted or the output register is stalled. Reset
// (synchronous, active low) empties the line and output.
// ============================================================================
module terminal_line_editor_echo #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] out_kind, [1] line_end
    output logic       m_axis_tlast
);

    tle_pkg::t_dp_cmd    w_cmd;
    tle_pkg::t_dp_status w_status;

    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (s_axis_tvalid),
        .o_rx_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tle_dp #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (s_axis_tdata),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_byte     (m_axis_tdata),
        .o_out_kind     (m_axis_tuser[0]),
        .o_out_line_end (m_axis_tuser[1]),
        .o_out_last     (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // Input is only taken when the output register can take its echo word.
    a_ready_needs_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
        else $error("input ready while output register is blocked");

    // The end of a line is a line word and closes the current byte's words.
    a_line_end_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] && m_axis_tlast))
        else $error("line end without line kind or last");

    // While a line is still being handed over, no new byte is taken.
    a_line_stalls_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input accepted in the middle of a line");
`endif

endmodule
